### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is ignored while reset is asserted.
`define LFPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also holds during reset.
`define LFPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// Line follower PD controller package
// Constants, shared types and helper functions of the controller.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int SENSOR_COUNT = 7;
    localparam int SAMPLE_BITS  = 10;
    localparam int SMP_W        = SAMPLE_BITS;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);

    localparam int NORM_FULL     = 1000;
    localparam int NORM_W        = 10;
    localparam int POS_W         = 13;
    localparam int WIDE_COUNT    = 5;
    localparam int WIDE_HIGH_POS = 4000;
    localparam int WIDE_LOW_POS  = 2000;
    localparam int NO_LINE_POS   = (SENSOR_COUNT - 1) * 500;
    localparam int PWM_MAX       = 255;
    localparam int GAIN_SCALE    = 1000;

    localparam int ERR_W = 16;
    localparam int ACC_W = 28;
    localparam int DRV_W = 20;

    // The PD sum magnitude stays below 2**26, where this reciprocal gives an exact
    // truncated quotient by GAIN_SCALE.
    localparam int RCP_W     = 27;
    localparam int RCP_SHIFT = 36;
    localparam int PROD_W    = ACC_W - 2 + RCP_W;
    localparam logic [RCP_W-1:0] GAIN_RECIP =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'(GAIN_SCALE) - 64'd1) / 64'(GAIN_SCALE));

    localparam int DIV_W     = 27;
    localparam int DVS_W     = 13;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [2:0] CFG_MOTOR_TRIM = 3'd0;
    localparam logic [2:0] CFG_BASE_SPEED = 3'd1;
    localparam logic [2:0] CFG_PROP_GAIN  = 3'd2;
    localparam logic [2:0] CFG_DERIV_GAIN = 3'd3;
    localparam logic [2:0] CFG_DEADBAND   = 3'd4;
    localparam logic [2:0] CFG_CENTER     = 3'd5;
    localparam logic [2:0] CFG_LEVEL      = 3'd6;

    localparam logic [1:0] CMD_CAL_START  = 2'd0;
    localparam logic [1:0] CMD_CAL_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_FOLLOW     = 2'd2;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [POS_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
        return POS_W'(idx) * POS_W'(NORM_FULL);
    endfunction

    function automatic logic [7:0] drive_mag(input logic signed [DRV_W-1:0] v);
        logic signed [DRV_W-1:0] a;
        a = v[DRV_W-1] ? -v : v;
        return (a > DRV_W'(PWM_MAX)) ? 8'(PWM_MAX) : a[7:0];
    endfunction

endpackage

### hdl/lfpd_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpd_div import lfpd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       rem_sh;
    logic [DVS_W:0]       rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/line_follower_pd_controller_unit.sv
// Calibration and undefined commands go straight to S_FIN, which presents their result once the output is free.
// A follow transaction normalizes each sensor in turn: a calibrated sensor goes through the
// shared 27-step divider and an uncalibrated one skips it; a seen line then runs the divider
// for the position average, and the PD step follows unless the wide-line sequencer or a junction stops the frame.
// The next transaction is accepted in the cycle after the result is loaded; a stalled result holds it.
// Synchronous active-low reset restores register defaults, calibration and PD state.
// ----------------------------------------------------------------------------
// Line follower PD controller
// Normalizes reflectance frames, finds the line position, runs the wide-line
// sequencer and a deadbanded PD step to produce signed-magnitude motor drive.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_follower_pd_controller_unit import lfpd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [12:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [9:0]        s_sensor_0,
    input  logic [9:0]        s_sensor_1,
    input  logic [9:0]        s_sensor_2,
    input  logic [9:0]        s_sensor_3,
    input  logic [9:0]        s_sensor_4,
    input  logic [9:0]        s_sensor_5,
    input  logic [9:0]        s_sensor_6,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_drive_update,
    output logic              m_left_reverse,
    output logic [7:0]        m_left_pwm,
    output logic              m_right_reverse,
    output logic [7:0]        m_right_pwm,
    output logic              m_junction_stop,
    output logic [POS_W-1:0]  m_line_position,
    output logic [CNT_W-1:0]  m_on_line_count
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NPREP = 4'd1;
    localparam logic [3:0] S_NWAIT = 4'd2;
    localparam logic [3:0] S_NACC  = 4'd3;
    localparam logic [3:0] S_POS   = 4'd4;
    localparam logic [3:0] S_POSW  = 4'd5;
    localparam logic [3:0] S_PHASE = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_MUL1  = 4'd8;
    localparam logic [3:0] S_MUL2  = 4'd9;
    localparam logic [3:0] S_CDIV  = 4'd10;
    localparam logic [3:0] S_CWAIT = 4'd11;
    localparam logic [3:0] S_DRIVE = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    localparam logic [1:0] PH_FOLLOW = 2'd0;
    localparam logic [1:0] PH_TURN   = 2'd1;
    localparam logic [1:0] PH_CROSS  = 2'd2;
    localparam logic [1:0] PH_EXIT   = 2'd3;

    localparam logic [SMP_W-1:0] SMP_FULL = {SMP_W{1'b1}};

    logic [SMP_W-1:0] raw_in [SENSOR_COUNT];

    assign raw_in[0] = s_sensor_0[SMP_W-1:0];
    assign raw_in[1] = s_sensor_1[SMP_W-1:0];
    assign raw_in[2] = s_sensor_2[SMP_W-1:0];
    assign raw_in[3] = s_sensor_3[SMP_W-1:0];
    assign raw_in[4] = s_sensor_4[SMP_W-1:0];
    assign raw_in[5] = s_sensor_5[SMP_W-1:0];
    assign raw_in[6] = s_sensor_6[SMP_W-1:0];

    logic [3:0]              state_reg, state_next;
    logic signed [7:0]       trim_reg, trim_next;
    logic [7:0]              base_reg, base_next;
    logic [9:0]              pg_reg, pg_next;
    logic [10:0]             dg_reg, dg_next;
    logic [12:0]             deadband_reg, deadband_next;
    logic [12:0]             center_reg, center_next;
    logic [9:0]              level_reg, level_next;
    logic [SMP_W-1:0]        cal_min_reg [SENSOR_COUNT];
    logic [SMP_W-1:0]        cal_min_next [SENSOR_COUNT];
    logic [SMP_W-1:0]        cal_max_reg [SENSOR_COUNT];
    logic [SMP_W-1:0]        cal_max_next [SENSOR_COUNT];
    logic [1:0]              phase_reg, phase_next;
    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;
    logic signed [ERR_W-1:0] prev_sm_reg, prev_sm_next;
    logic                    m_valid_reg, m_valid_next;

    logic [SMP_W-1:0]        raw_reg [SENSOR_COUNT];
    logic [SMP_W-1:0]        raw_next [SENSOR_COUNT];
    logic [1:0]              cmd_reg, cmd_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [NORM_W-1:0]       norm_reg, norm_next;
    logic [DIV_W-1:0]        wsum_reg, wsum_next;
    logic [DVS_W-1:0]        vsum_reg, vsum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic signed [DRV_W-1:0] corr_reg, corr_next;
    logic                    r_upd_reg, r_upd_next;
    logic                    r_lrev_reg, r_lrev_next;
    logic [7:0]              r_lpwm_reg, r_lpwm_next;
    logic                    r_rrev_reg, r_rrev_next;
    logic [7:0]              r_rpwm_reg, r_rpwm_next;
    logic                    r_junc_reg, r_junc_next;
    logic                    o_upd_reg, o_upd_next;
    logic                    o_lrev_reg, o_lrev_next;
    logic [7:0]              o_lpwm_reg, o_lpwm_next;
    logic                    o_rrev_reg, o_rrev_next;
    logic [7:0]              o_rpwm_reg, o_rpwm_next;
    logic                    o_junc_reg, o_junc_next;
    logic [POS_W-1:0]        o_pos_reg, o_pos_next;
    logic [CNT_W-1:0]        o_cnt_reg, o_cnt_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    lfpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        logic [SMP_W-1:0]        raw_v;
        logic [SMP_W-1:0]        mn_v;
        logic [SMP_W-1:0]        mx_v;
        logic [SMP_W-1:0]        mnew_v;
        logic [1:0]              ph_v;
        logic                    stop_v;
        logic                    junc_v;
        logic signed [ERR_W-1:0] err_v;
        logic signed [ERR_W-1:0] mag_v;
        logic signed [ERR_W-1:0] d_v;
        logic signed [ERR_W+1:0] d3_v;
        logic signed [ERR_W+1:0] d3r_v;
        logic signed [ERR_W-1:0] q1_v;
        logic signed [ERR_W-1:0] p_v;
        logic signed [ERR_W-1:0] q2_v;
        logic signed [ACC_W-1:0] amag_v;
        logic [PROD_W-1:0]       prod_v;
        logic signed [DRV_W-1:0] base_v;
        logic signed [DRV_W-1:0] trim_v;
        logic signed [DRV_W-1:0] left_v;
        logic signed [DRV_W-1:0] right_v;
        logic signed [DRV_W-1:0] dl_v;
        logic signed [DRV_W-1:0] dr_v;
        logic                    put_v;

        state_next    = state_reg;
        trim_next     = trim_reg;
        base_next     = base_reg;
        pg_next       = pg_reg;
        dg_next       = dg_reg;
        deadband_next = deadband_reg;
        center_next   = center_reg;
        level_next    = level_reg;
        cal_min_next  = cal_min_reg;
        cal_max_next  = cal_max_reg;
        phase_next    = phase_reg;
        prev_err_next = prev_err_reg;
        prev_sm_next  = prev_sm_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        raw_next      = raw_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        norm_next     = norm_reg;
        wsum_next     = wsum_reg;
        vsum_next     = vsum_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        err_next      = err_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        corr_next     = corr_reg;
        r_upd_next    = r_upd_reg;
        r_lrev_next   = r_lrev_reg;
        r_lpwm_next   = r_lpwm_reg;
        r_rrev_next   = r_rrev_reg;
        r_rpwm_next   = r_rpwm_reg;
        r_junc_next   = r_junc_reg;
        o_upd_next    = o_upd_reg;
        o_lrev_next   = o_lrev_reg;
        o_lpwm_next   = o_lpwm_reg;
        o_rrev_next   = o_rrev_reg;
        o_rpwm_next   = o_rpwm_reg;
        o_junc_next   = o_junc_reg;
        o_pos_next    = o_pos_reg;
        o_cnt_next    = o_cnt_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        raw_v   = raw_reg[idx_reg];
        mn_v    = cal_min_reg[idx_reg];
        mx_v    = cal_max_reg[idx_reg];
        mnew_v  = (raw_v < mn_v) ? raw_v : mn_v;
        ph_v    = phase_reg;
        stop_v  = 1'b0;
        junc_v  = 1'b0;

        err_v   = $signed(ERR_W'(pos_reg)) - $signed(ERR_W'(center_reg));
        mag_v   = err_v[ERR_W-1] ? -err_v : err_v;
        d_v     = err_v - prev_err_reg;
        d3_v    = {d_v[ERR_W-1], d_v, 1'b0} + {{2{d_v[ERR_W-1]}}, d_v};
        d3r_v   = d3_v + {{ERR_W{1'b0}}, d3_v[ERR_W+1], d3_v[ERR_W+1]};
        q1_v    = ERR_W'(d3r_v >>> 2);
        p_v     = prev_sm_reg + {{(ERR_W-2){1'b0}}, prev_sm_reg[ERR_W-1], prev_sm_reg[ERR_W-1]};
        q2_v    = p_v >>> 2;
        amag_v  = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        prod_v  = PROD_W'(amag_v[ACC_W-3:0]) * PROD_W'(GAIN_RECIP);

        base_v  = DRV_W'(base_reg);
        trim_v  = DRV_W'(trim_reg);
        left_v  = base_v + corr_reg;
        right_v = base_v + trim_v - corr_reg;
        dl_v    = left_v;
        dr_v    = right_v;
        put_v   = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_MOTOR_TRIM: trim_next     = cfg_data[7:0];
                CFG_BASE_SPEED: base_next     = cfg_data[7:0];
                CFG_PROP_GAIN:  pg_next       = cfg_data[9:0];
                CFG_DERIV_GAIN: dg_next       = cfg_data[10:0];
                CFG_DEADBAND:   deadband_next = cfg_data;
                CFG_CENTER:     center_next   = cfg_data;
                CFG_LEVEL:      level_next    = cfg_data[9:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    raw_next    = raw_in;
                    cmd_next    = s_cmd;
                    idx_next    = '0;
                    wsum_next   = '0;
                    vsum_next   = '0;
                    cnt_next    = '0;
                    pos_next    = '0;
                    r_upd_next  = 1'b0;
                    r_lrev_next = 1'b0;
                    r_lpwm_next = '0;
                    r_rrev_next = 1'b0;
                    r_rpwm_next = '0;
                    r_junc_next = 1'b0;
                    state_next  = S_FIN;
                    if (s_cmd == CMD_CAL_START) begin
                        for (int i = 0; i < SENSOR_COUNT; i++) begin
                            cal_min_next[i] = SMP_FULL;
                            cal_max_next[i] = '0;
                        end
                    end else if (s_cmd == CMD_CAL_SAMPLE) begin
                        for (int i = 0; i < SENSOR_COUNT; i++) begin
                            if (raw_in[i] < cal_min_reg[i]) cal_min_next[i] = raw_in[i];
                            if (raw_in[i] > cal_max_reg[i]) cal_max_next[i] = raw_in[i];
                        end
                    end else if (s_cmd == CMD_FOLLOW) begin
                        state_next = S_NPREP;
                    end
                end
            end
            S_NPREP: begin
                if (mx_v > mn_v) begin
                    cal_min_next[idx_reg] = mnew_v;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(raw_v - mnew_v) * DIV_W'(NORM_FULL);
                    div_req.divisor  = DVS_W'(mx_v - mnew_v);
                    state_next       = S_NWAIT;
                end else begin
                    norm_next  = '0;
                    state_next = S_NACC;
                end
            end
            S_NWAIT: begin
                if (div_rsp.done) begin
                    norm_next  = (div_rsp.quotient > DIV_W'(NORM_FULL)) ?
                                 NORM_W'(NORM_FULL) : div_rsp.quotient[NORM_W-1:0];
                    state_next = S_NACC;
                end
            end
            S_NACC: begin
                if (norm_reg > level_reg) begin
                    wsum_next = wsum_reg + DIV_W'(norm_reg) * DIV_W'(sensor_weight(idx_reg));
                    vsum_next = vsum_reg + DVS_W'(norm_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (idx_reg == IDX_W'(SENSOR_COUNT - 1)) begin
                    state_next = S_POS;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_NPREP;
                end
            end
            S_POS: begin
                if (cnt_reg == '0) begin
                    pos_next   = POS_W'(NO_LINE_POS);
                    state_next = S_PHASE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = wsum_reg;
                    div_req.divisor  = vsum_reg;
                    state_next       = S_POSW;
                end
            end
            S_POSW: begin
                if (div_rsp.done) begin
                    if (cnt_reg > CNT_W'(WIDE_COUNT)) begin
                        pos_next = (div_rsp.quotient > DIV_W'(center_reg)) ?
                                   POS_W'(WIDE_HIGH_POS) : POS_W'(WIDE_LOW_POS);
                    end else begin
                        pos_next = div_rsp.quotient[POS_W-1:0];
                    end
                    state_next = S_PHASE;
                end
            end
            S_PHASE: begin
                if (ph_v == PH_EXIT) begin
                    if (cnt_reg != '0) ph_v = PH_FOLLOW;
                    else stop_v = 1'b1;
                end
                if (!stop_v && ph_v == PH_TURN) begin
                    if (cnt_reg == '0) ph_v = PH_CROSS;
                    else stop_v = 1'b1;
                end
                if (!stop_v && ph_v != PH_CROSS && cnt_reg == '0) begin
                    junc_v = 1'b1;
                    stop_v = 1'b1;
                end
                phase_next  = ph_v;
                r_upd_next  = junc_v;
                r_junc_next = junc_v;
                state_next  = stop_v ? S_FIN : S_ERR;
            end
            S_ERR: begin
                err_next      = err_v;
                prev_err_next = err_v;
                if ($unsigned(mag_v) >= ERR_W'(deadband_reg)) begin
                    prev_sm_next = q1_v + q2_v;
                    state_next   = S_MUL1;
                end else begin
                    acc_next   = '0;
                    state_next = S_CDIV;
                end
            end
            S_MUL1: begin
                acc_next   = ACC_W'($signed({1'b0, pg_reg})) * ACC_W'(err_reg);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                acc_next   = acc_reg + ACC_W'($signed({1'b0, dg_reg})) * ACC_W'(prev_sm_reg);
                state_next = S_CDIV;
            end
            S_CDIV: begin
                neg_next   = acc_reg[ACC_W-1];
                corr_next  = DRV_W'(prod_v[PROD_W-1:RCP_SHIFT]);
                state_next = S_CWAIT;
            end
            S_CWAIT: begin
                corr_next  = neg_reg ? -corr_reg : corr_reg;
                state_next = S_DRIVE;
            end
            S_DRIVE: begin
                if (cnt_reg > CNT_W'(WIDE_COUNT)) begin
                    if (phase_reg == PH_FOLLOW) begin
                        dl_v       = -right_v;
                        dr_v       = -left_v;
                        put_v      = 1'b1;
                        phase_next = PH_TURN;
                    end else if (phase_reg == PH_CROSS) begin
                        dl_v       = base_v;
                        dr_v       = base_v + trim_v;
                        put_v      = 1'b1;
                        phase_next = PH_EXIT;
                    end
                end else begin
                    put_v = 1'b1;
                end
                if (put_v) begin
                    r_upd_next  = 1'b1;
                    r_lrev_next = dl_v[DRV_W-1];
                    r_lpwm_next = drive_mag(dl_v);
                    r_rrev_next = dr_v[DRV_W-1];
                    r_rpwm_next = drive_mag(dr_v);
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_upd_next   = r_upd_reg;
                    o_lrev_next  = r_lrev_reg;
                    o_lpwm_next  = r_lpwm_reg;
                    o_rrev_next  = r_rrev_reg;
                    o_rpwm_next  = r_rpwm_reg;
                    o_junc_next  = r_junc_reg;
                    o_pos_next   = pos_reg;
                    o_cnt_next   = cnt_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            trim_reg     <= '0;
            base_reg     <= 8'd70;
            pg_reg       <= 10'd20;
            dg_reg       <= 11'd50;
            deadband_reg <= 13'd1000;
            center_reg   <= 13'd3000;
            level_reg    <= 10'd500;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                cal_min_reg[i] <= SMP_FULL;
                cal_max_reg[i] <= '0;
            end
            phase_reg    <= PH_FOLLOW;
            prev_err_reg <= '0;
            prev_sm_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            trim_reg     <= trim_next;
            base_reg     <= base_next;
            pg_reg       <= pg_next;
            dg_reg       <= dg_next;
            deadband_reg <= deadband_next;
            center_reg   <= center_next;
            level_reg    <= level_next;
            cal_min_reg  <= cal_min_next;
            cal_max_reg  <= cal_max_next;
            phase_reg    <= phase_next;
            prev_err_reg <= prev_err_next;
            prev_sm_reg  <= prev_sm_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg    <= raw_next;
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        norm_reg   <= norm_next;
        wsum_reg   <= wsum_next;
        vsum_reg   <= vsum_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        err_reg    <= err_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        corr_reg   <= corr_next;
        r_upd_reg  <= r_upd_next;
        r_lrev_reg <= r_lrev_next;
        r_lpwm_reg <= r_lpwm_next;
        r_rrev_reg <= r_rrev_next;
        r_rpwm_reg <= r_rpwm_next;
        r_junc_reg <= r_junc_next;
        o_upd_reg  <= o_upd_next;
        o_lrev_reg <= o_lrev_next;
        o_lpwm_reg <= o_lpwm_next;
        o_rrev_reg <= o_rrev_next;
        o_rpwm_reg <= o_rpwm_next;
        o_junc_reg <= o_junc_next;
        o_pos_reg  <= o_pos_next;
        o_cnt_reg  <= o_cnt_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_update  = o_upd_reg;
    assign m_left_reverse  = o_lrev_reg;
    assign m_left_pwm      = o_lpwm_reg;
    assign m_right_reverse = o_rrev_reg;
    assign m_right_pwm     = o_rpwm_reg;
    assign m_junction_stop = o_junc_reg;
    assign m_line_position = o_pos_reg;
    assign m_on_line_count = o_cnt_reg;

    // The divider is only started during a follow transaction, which cmd_reg marks.
    `LFPD_ASSERT(a_div_start_busy, div_req.start |-> cmd_reg == CMD_FOLLOW && state_reg != S_IDLE, "divider started outside a follow transaction")
    `LFPD_ASSERT(a_accept_leaves_idle, s_valid && s_ready |=> state_reg == S_NPREP || state_reg == S_FIN, "accepted transaction did not start the sequencer")
    `LFPD_ASSERT_ALWAYS(a_junction_stopped, m_valid && m_junction_stop |-> m_drive_update && m_left_pwm == 8'd0 && m_right_pwm == 8'd0, "junction stop with motors running")

endmodule

### sim/lfpd_checker.sv
// ----------------------------------------------------------------------------
// Line follower PD controller checker
// Watches the configuration port and both channels of the controller. It
// predicts every result from the accepted input transactions and compares the
// result transactions with the predictions, field by field and in order.
// ----------------------------------------------------------------------------
module lfpd_checker import lfpd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [12:0]      cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_cmd,
    input  logic [9:0]       s_sensor_0,
    input  logic [9:0]       s_sensor_1,
    input  logic [9:0]       s_sensor_2,
    input  logic [9:0]       s_sensor_3,
    input  logic [9:0]       s_sensor_4,
    input  logic [9:0]       s_sensor_5,
    input  logic [9:0]       s_sensor_6,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic             m_drive_update,
    input  logic             m_left_reverse,
    input  logic [7:0]       m_left_pwm,
    input  logic             m_right_reverse,
    input  logic [7:0]       m_right_pwm,
    input  logic             m_junction_stop,
    input  logic [POS_W-1:0] m_line_position,
    input  logic [CNT_W-1:0] m_on_line_count,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic             drive_update;
        logic             left_reverse;
        logic [7:0]       left_pwm;
        logic             right_reverse;
        logic [7:0]       right_pwm;
        logic             junction_stop;
        logic [POS_W-1:0] line_position;
        logic [CNT_W-1:0] on_line_count;
    } drive_result_t;

    drive_result_t expected_drive_q[$];

    int trim, base, kp, kd, deadband, center, level;
    int win_lo[SENSOR_COUNT];
    int win_hi[SENSOR_COUNT];
    int wide_phase, last_err, last_smooth;

    function automatic logic [7:0] clamp_mag(input longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return (a > PWM_MAX) ? 8'(PWM_MAX) : 8'(a);
    endfunction

    function automatic drive_result_t with_drive(input drive_result_t r, input longint lv,
                                                 input longint rv);
        r.drive_update  = 1'b1;
        r.left_reverse  = (lv < 0);
        r.left_pwm      = clamp_mag(lv);
        r.right_reverse = (rv < 0);
        r.right_pwm     = clamp_mag(rv);
        return r;
    endfunction

    function automatic drive_result_t predict_drive(input logic [1:0] cmd,
                                                    input logic [6:0][9:0] smp);
        drive_result_t r;
        int n, cnt, pos, err, mag, d, sm, corr;
        longint wsum, vsum, avg, acc, lv, rv;
        r = '0;
        wsum = 0;
        vsum = 0;
        cnt = 0;
        corr = 0;
        if (cmd == CMD_CAL_START) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                win_lo[i] = 1023;
                win_hi[i] = 0;
            end
            return r;
        end
        if (cmd == CMD_CAL_SAMPLE) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (int'(smp[i]) < win_lo[i]) win_lo[i] = smp[i];
                if (int'(smp[i]) > win_hi[i]) win_hi[i] = smp[i];
            end
            return r;
        end
        if (cmd != CMD_FOLLOW) return r;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            n = 0;
            if (win_hi[i] > win_lo[i]) begin
                if (int'(smp[i]) < win_lo[i]) win_lo[i] = smp[i];
                n = (int'(smp[i]) - win_lo[i]) * NORM_FULL / (win_hi[i] - win_lo[i]);
                if (n > NORM_FULL) n = NORM_FULL;
            end
            if (n > level) begin
                wsum += longint'(n) * i * 1000;
                vsum += n;
                cnt++;
            end
        end
        if (cnt == 0) begin
            pos = NO_LINE_POS;
        end else begin
            avg = wsum / vsum;
            if (cnt > WIDE_COUNT) pos = (avg > center) ? WIDE_HIGH_POS : WIDE_LOW_POS;
            else pos = int'(avg);
        end
        r.line_position = POS_W'(pos);
        r.on_line_count = CNT_W'(cnt);
        if (wide_phase == 3) begin
            if (cnt > 0) wide_phase = 0;
            else return r;
        end
        if (wide_phase == 1) begin
            if (cnt == 0) wide_phase = 2;
            else return r;
        end
        if (wide_phase != 2 && cnt == 0) begin
            r.drive_update  = 1'b1;
            r.junction_stop = 1'b1;
            return r;
        end
        err = pos - center;
        mag = (err < 0) ? -err : err;
        if (mag >= deadband) begin
            d = err - last_err;
            sm = (d * 3) / 4 + last_smooth / 4;
            last_smooth = sm;
            acc = longint'(kp) * err + longint'(kd) * sm;
            corr = int'(acc / 1000);
        end
        last_err = err;
        lv = longint'(base) + corr;
        rv = longint'(base) + trim - corr;
        if (cnt > WIDE_COUNT) begin
            if (wide_phase == 0) begin
                r = with_drive(r, -rv, -lv);
                wide_phase = 1;
            end else if (wide_phase == 2) begin
                r = with_drive(r, base, longint'(base) + trim);
                wide_phase = 3;
            end
        end else begin
            r = with_drive(r, lv, rv);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        fail_count++;
    endtask

    assign pending = expected_drive_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        drive_result_t want;
        if (!aresetn) begin
            expected_drive_q.delete();
            trim = 0;
            base = 70;
            kp = 20;
            kd = 50;
            deadband = 1000;
            center = 3000;
            level = 500;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                win_lo[i] = 1023;
                win_hi[i] = 0;
            end
            wide_phase = 0;
            last_err = 0;
            last_smooth = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MOTOR_TRIM: trim = int'($signed(cfg_data[7:0]));
                    CFG_BASE_SPEED: base = cfg_data[7:0];
                    CFG_PROP_GAIN:  kp = cfg_data[9:0];
                    CFG_DERIV_GAIN: kd = cfg_data[10:0];
                    CFG_DEADBAND:   deadband = cfg_data;
                    CFG_CENTER:     center = cfg_data;
                    CFG_LEVEL:      level = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_drive_q.size() == 0) begin
                    $display("result transaction with no prediction waiting");
                    fail_count++;
                end else begin
                    want = expected_drive_q.pop_front();
                    if (m_drive_update != want.drive_update)
                        report_mismatch("drive_update", m_drive_update, want.drive_update);
                    if (m_left_reverse != want.left_reverse)
                        report_mismatch("left_reverse", m_left_reverse, want.left_reverse);
                    if (m_left_pwm != want.left_pwm)
                        report_mismatch("left_pwm", m_left_pwm, want.left_pwm);
                    if (m_right_reverse != want.right_reverse)
                        report_mismatch("right_reverse", m_right_reverse, want.right_reverse);
                    if (m_right_pwm != want.right_pwm)
                        report_mismatch("right_pwm", m_right_pwm, want.right_pwm);
                    if (m_junction_stop != want.junction_stop)
                        report_mismatch("junction_stop", m_junction_stop, want.junction_stop);
                    if (m_line_position != want.line_position)
                        report_mismatch("line_position", m_line_position, want.line_position);
                    if (m_on_line_count != want.on_line_count)
                        report_mismatch("on_line_count", m_on_line_count, want.on_line_count);
                end
            end
            if (s_valid && s_ready) begin
                expected_drive_q.push_back(predict_drive(s_cmd, {s_sensor_6, s_sensor_5,
                    s_sensor_4, s_sensor_3, s_sensor_2, s_sensor_1, s_sensor_0}));
            end
        end
    end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Line follower PD controller testbench
// Drives calibration runs and follow frames shaped like real track scenes
// through several register settings, with random idling on both channels, and
// gives the verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module testbench import lfpd_pkg::*;;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1250;

    typedef enum int {SCENE_LOST, SCENE_WIDE, SCENE_TRACK, SCENE_NOISE} scene_e;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [12:0]      cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_cmd = '0;
    logic [9:0]       s_sensor_0 = '0;
    logic [9:0]       s_sensor_1 = '0;
    logic [9:0]       s_sensor_2 = '0;
    logic [9:0]       s_sensor_3 = '0;
    logic [9:0]       s_sensor_4 = '0;
    logic [9:0]       s_sensor_5 = '0;
    logic [9:0]       s_sensor_6 = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_drive_update;
    logic             m_left_reverse;
    logic [7:0]       m_left_pwm;
    logic             m_right_reverse;
    logic [7:0]       m_right_pwm;
    logic             m_junction_stop;
    logic [POS_W-1:0] m_line_position;
    logic [CNT_W-1:0] m_on_line_count;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    bit               no_idle = 1'b0;

    line_follower_pd_controller_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_sensor_0(s_sensor_0), .s_sensor_1(s_sensor_1), .s_sensor_2(s_sensor_2),
        .s_sensor_3(s_sensor_3), .s_sensor_4(s_sensor_4), .s_sensor_5(s_sensor_5),
        .s_sensor_6(s_sensor_6),
        .m_valid(m_valid), .m_ready(m_ready), .m_drive_update(m_drive_update),
        .m_left_reverse(m_left_reverse), .m_left_pwm(m_left_pwm),
        .m_right_reverse(m_right_reverse), .m_right_pwm(m_right_pwm),
        .m_junction_stop(m_junction_stop), .m_line_position(m_line_position),
        .m_on_line_count(m_on_line_count)
    );

    lfpd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_sensor_0(s_sensor_0), .s_sensor_1(s_sensor_1), .s_sensor_2(s_sensor_2),
        .s_sensor_3(s_sensor_3), .s_sensor_4(s_sensor_4), .s_sensor_5(s_sensor_5),
        .s_sensor_6(s_sensor_6),
        .m_valid(m_valid), .m_ready(m_ready), .m_drive_update(m_drive_update),
        .m_left_reverse(m_left_reverse), .m_left_pwm(m_left_pwm),
        .m_right_reverse(m_right_reverse), .m_right_pwm(m_right_pwm),
        .m_junction_stop(m_junction_stop), .m_line_position(m_line_position),
        .m_on_line_count(m_on_line_count),
        .fail_count(fail_count), .pending(pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= no_idle || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_item(input logic [1:0] cmd, input logic [6:0][9:0] smp);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_sensor_0 <= smp[0];
        s_sensor_1 <= smp[1];
        s_sensor_2 <= smp[2];
        s_sensor_3 <= smp[3];
        s_sensor_4 <= smp[4];
        s_sensor_5 <= smp[5];
        s_sensor_6 <= smp[6];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!no_idle && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 400)) @(posedge aclk);
            else repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic write_settings(input int v0, input int v1, input int v2, input int v3,
                                  input int v4, input int v5, input int v6);
        int vals[7];
        vals = '{v0, v1, v2, v3, v4, v5, v6};
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= 13'(vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [6:0][9:0] scene_frame(input scene_e scene);
        logic [6:0][9:0] f;
        int c, w;
        for (int i = 0; i < 7; i++) f[i] = 10'($urandom_range(0, 250));
        case (scene)
            SCENE_WIDE: begin
                w = $urandom_range(6, 7);
                c = $urandom_range(0, 7 - w);
                for (int i = c; i < c + w; i++) f[i] = 10'($urandom_range(650, 1023));
            end
            SCENE_TRACK: begin
                w = $urandom_range(1, 4);
                c = $urandom_range(0, 7 - w);
                for (int i = c; i < c + w; i++) f[i] = 10'($urandom_range(500, 1023));
            end
            SCENE_NOISE: begin
                for (int i = 0; i < 7; i++) f[i] = 10'($urandom);
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic calibrate(input int samples);
        logic [6:0][9:0] f;
        send_item(CMD_CAL_START, 70'({$urandom, $urandom, $urandom}));
        for (int k = 0; k < samples; k++) begin
            for (int i = 0; i < 7; i++) f[i] = 10'($urandom);
            if (k == 0) f = '0;
            if (k == 1) f = {7{10'h3ff}};
            send_item(CMD_CAL_SAMPLE, f);
        end
    endtask

    initial begin
        int pick;
        scene_e scene;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Follow before calibration: every window is empty and the line is lost.
        send_item(CMD_FOLLOW, {7{10'h3ff}});
        send_item(CMD_UNUSED, {7{10'h3ff}});
        send_item(CMD_CAL_SAMPLE, {7{10'd100}});
        send_item(CMD_FOLLOW, {7{10'd100}});
        send_item(CMD_CAL_SAMPLE, {7{10'd900}});
        send_item(CMD_FOLLOW, {7{10'h3ff}});
        send_item(CMD_FOLLOW, '0);
        send_item(CMD_FOLLOW, '0);
        send_item(CMD_FOLLOW, {10'd0, 10'd0, 10'd0, 10'd900, 10'd0, 10'd0, 10'd0});
        send_item(CMD_FOLLOW, {10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        send_item(CMD_FOLLOW, {10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023});
        send_item(CMD_FOLLOW, {7{10'd900}});
        send_item(CMD_FOLLOW, {7{10'd900}});
        send_item(CMD_FOLLOW, '0);
        send_item(CMD_FOLLOW, {10'd0, {6{10'd900}}});
        send_item(CMD_FOLLOW, '0);
        send_item(CMD_FOLLOW, {10'd0, 10'd0, 10'd900, 10'd0, 10'd0, 10'd0, 10'd0});
        send_item(CMD_CAL_START, '0);
        send_item(CMD_CAL_SAMPLE, '0);
        send_item(CMD_FOLLOW, {7{10'h3ff}});

        write_settings(-128, 0, 0, 0, 0, 0, 0);
        calibrate(3);
        for (int n = 0; n < 6; n++) send_item(CMD_FOLLOW, scene_frame(scene_e'(n % 4)));
        write_settings(127, 255, 1000, 2000, 6000, 6000, 1000);
        for (int n = 0; n < 6; n++) send_item(CMD_FOLLOW, scene_frame(scene_e'(n % 4)));
        write_settings(127, 255, 1000, 2000, 0, 0, 0);
        for (int n = 0; n < 6; n++) send_item(CMD_FOLLOW, scene_frame(scene_e'(n % 4)));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 500 && n < 700);
            if (n % 160 == 0) begin
                write_settings($urandom_range(0, 255) - 128, $urandom_range(0, 255),
                               $urandom_range(0, 1000), $urandom_range(0, 2000),
                               $urandom_range(0, 3000), $urandom_range(1000, 5000),
                               $urandom_range(0, 900));
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                calibrate($urandom_range(1, 6));
            end else if (pick < 7) begin
                send_item(CMD_UNUSED, scene_frame(SCENE_NOISE));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) scene = SCENE_LOST;
                else if (pick < 42) scene = SCENE_WIDE;
                else if (pick < 90) scene = SCENE_TRACK;
                else scene = SCENE_NOISE;
                send_item(CMD_FOLLOW, scene_frame(scene));
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### line_follower_pd_controller_unit.f
+incdir+hdl
hdl/lfpd_pkg.sv
hdl/lfpd_div.sv
hdl/line_follower_pd_controller_unit.sv
sim/lfpd_checker.sv
sim/testbench.sv
